[rtl/pim_pkg.sv]
// Shared constants and codes for the point-in-mesh ray parity block.
`default_nettype none
package pim_pkg;

   // default store depths
   localparam int MAX_VERTICES_DEF = 1024;
   localparam int MAX_FACES_DEF    = 1024;

   // field widths fixed by the interface
   localparam int COORD_W = 32;
   localparam int INDEX_W = 10;
   localparam int COUNT_W = 11;

   // request command codes
   typedef enum logic [1:0] {
      CMD_LOAD_VERTEX = 2'd0,
      CMD_LOAD_FACE   = 2'd1,
      CMD_QUERY       = 2'd2,
      CMD_NONE        = 2'd3
   } command_type;

   // register index of face_count
   localparam logic REG_FACE_COUNT = 1'b0;

endpackage
`default_nettype wire

[rtl/pim_ram.sv]
// Generic single-port synchronous RAM with registered read data.
`default_nettype none
module pim_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    addr,
   input  wire logic [WIDTH-1:0] wdata,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write at addr, read registered at the same addr
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

[rtl/point_in_mesh_ray_parity.sv]
// Point-in-mesh test: +Z ray parity over a stored triangle mesh.
//
// Usage: the req_ channel carries one request per handshake. A load-vertex
// or load-face request writes one entry of the vertex or face memory in the
// cycle it is accepted and gives no response. A query request casts a +Z ray
// from the given point against faces 0 .. min(face_count, MAX_FACES)-1 and
// gives one rsp_ item: the hit count and its parity (inside_res).
// Each face takes one face-memory read, three vertex-memory reads
// on the single vertex port, an edge-forming step, sixteen passes through
// one shared 33x35 multiplier, and the final accumulate and compare steps.
// req_ready is low while a query runs, so the next request is taken only
// once its response is registered. When the receiver stalls, the finished
// response waits in the output register; load requests are still taken
// meanwhile, and a following query runs and then holds until the output
// register frees. Reset clears face_count to zero and all control state;
// memory contents stay undefined until loaded. The user must write the
// face_count register through the APB port at address 0 only while the
// block is idle; the block itself does not enforce this.
`default_nettype none
module point_in_mesh_ray_parity
   import pim_pkg::*;
#(
   parameter int MAX_VERTICES = MAX_VERTICES_DEF,
   parameter int MAX_FACES    = MAX_FACES_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // request channel
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [1:0]         req_command,
   input  wire logic [INDEX_W-1:0] req_slot,
   input  wire logic [COORD_W-1:0] req_x_coord,
   input  wire logic [COORD_W-1:0] req_y_coord,
   input  wire logic [COORD_W-1:0] req_z_coord,
   input  wire logic [INDEX_W-1:0] req_corner_a,
   input  wire logic [INDEX_W-1:0] req_corner_b,
   input  wire logic [INDEX_W-1:0] req_corner_c,
   // response channel
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic                    rsp_inside_res,
   output logic [COUNT_W-1:0]      rsp_hit_count,
   // configuration port
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [2:0]         paddr,
   input  wire logic [31:0]        pwdata,
   output logic      [31:0]        prdata,
   output logic                    pready
);

   localparam int VAW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int FAW = (MAX_FACES > 1) ? $clog2(MAX_FACES) : 1;
   localparam int FCW = $clog2(MAX_FACES + 1);
   localparam int VW  = 3 * COORD_W;
   localparam int FW  = 3 * INDEX_W;
   localparam int DW  = COORD_W + 1;   // edge and offset width
   localparam int AW2 = 68;            // det, u, v, qx, qy accumulators
   localparam int TW  = 104;           // t accumulator
   localparam int RW  = 70;            // det - u - v
   localparam int LOW = 34;            // split point of the wide operand

   typedef enum logic [3:0] {
      S_IDLE, S_FACE, S_VA, S_VB, S_VC, S_VD, S_MUL, S_DRAIN,
      S_CMP1, S_CMP2, S_DONE
   } state_type;

   state_type          state_ff;
   logic [FCW-1:0]     face_idx_ff, n_ff;
   logic [COUNT_W-1:0] hits_ff;
   logic [COUNT_W-1:0] face_count_ff;
   logic               rsp_valid_ff, rsp_inside_ff;
   logic [COUNT_W-1:0] rsp_hit_count_ff;

   logic [COORD_W-1:0] px_ff, py_ff, pz_ff;
   logic [COORD_W-1:0] v0x_ff, v0y_ff, v0z_ff, vbx_ff, vby_ff, vbz_ff;
   logic [INDEX_W-1:0] cb_ff, cc_ff;
   logic [DW-1:0]      e1x_ff, e1y_ff, e1z_ff, e2x_ff, e2y_ff, e2z_ff;
   logic [DW-1:0]      sx_ff, sy_ff, sz_ff;
   logic [3:0]         step_ff, pstep_ff;
   logic               pvalid_ff;
   logic [AW2-1:0]     prod_ff, det_ff, un_ff, vn_ff, qx_ff, qy_ff;
   logic [TW-1:0]      tn_ff;
   logic [RW-1:0]      r_ff;

   logic               req_fire, cfg_write;
   logic [VW-1:0]      vert_rdata;
   logic [FW-1:0]      face_rdata;
   logic [VAW-1:0]     vert_addr;
   logic [FAW-1:0]     face_addr;
   logic               vert_we, face_we;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign cfg_write = psel && penable && pwrite && pready;
   assign pready    = 1'b1;
   assign prdata    = (paddr[2] == REG_FACE_COUNT) ? 32'(face_count_ff) : 32'd0;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         face_count_ff <= '0;
      end else if (cfg_write && paddr[2] == REG_FACE_COUNT) begin
         face_count_ff <= pwdata[COUNT_W-1:0];
      end
   end

   // memory ports: loads while idle, query reads otherwise
   assign vert_we = req_fire && req_command == CMD_LOAD_VERTEX
                    && 32'(req_slot) < MAX_VERTICES;
   assign face_we = req_fire && req_command == CMD_LOAD_FACE
                    && 32'(req_slot) < MAX_FACES;
   assign face_addr = (state_ff == S_IDLE) ? FAW'(req_slot) : face_idx_ff[FAW-1:0];

   always_comb begin
      case (state_ff)
         S_VA:    vert_addr = VAW'(face_rdata[INDEX_W-1:0]);
         S_VB:    vert_addr = VAW'(cb_ff);
         S_VC:    vert_addr = VAW'(cc_ff);
         default: vert_addr = VAW'(req_slot);
      endcase
   end

   pim_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_vert_ram (
      .clock (clock),
      .we    (vert_we),
      .addr  (vert_addr),
      .wdata ({req_z_coord, req_y_coord, req_x_coord}),
      .rdata (vert_rdata)
   );

   pim_ram #(.WIDTH(FW), .DEPTH(MAX_FACES)) u_face_ram (
      .clock (clock),
      .we    (face_we),
      .addr  (face_addr),
      .wdata ({req_corner_c, req_corner_b, req_corner_a}),
      .rdata (face_rdata)
   );

   // face count clipped to the store depth
   logic [FCW-1:0] n_in;
   assign n_in = (32'(face_count_ff) > MAX_FACES) ? FCW'(MAX_FACES) : FCW'(face_count_ff);

   logic corners_ok;
   assign corners_ok = 32'(face_rdata[INDEX_W-1:0]) < MAX_VERTICES
                    && 32'(face_rdata[2*INDEX_W-1:INDEX_W]) < MAX_VERTICES
                    && 32'(face_rdata[3*INDEX_W-1:2*INDEX_W]) < MAX_VERTICES;

   logic last_face;
   assign last_face = (face_idx_ff + FCW'(1)) == n_ff;

   // hit decision, sign-scaled by det
   logic det_pos, hit;
   assign det_pos = !det_ff[AW2-1];
   always_comb begin
      if (det_pos) begin
         hit = !un_ff[AW2-1] && !vn_ff[AW2-1] && !tn_ff[TW-1] && !r_ff[RW-1];
      end else begin
         hit = (un_ff[AW2-1] || un_ff == '0) && (vn_ff[AW2-1] || vn_ff == '0)
            && (tn_ff[TW-1] || tn_ff == '0) && (r_ff[RW-1] || r_ff == '0);
      end
      hit = hit && (det_ff != '0);
   end

   // sequencer and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         face_idx_ff  <= '0;
         n_ff         <= '0;
         hits_ff      <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready && state_ff != S_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_fire && req_command == CMD_QUERY) begin
                  face_idx_ff <= '0;
                  n_ff        <= n_in;
                  hits_ff     <= '0;
                  state_ff    <= (n_in == '0) ? S_DONE : S_FACE;
               end
            end
            S_FACE: state_ff <= S_VA;
            S_VA: begin
               if (corners_ok) begin
                  state_ff <= S_VB;
               end else if (last_face) begin
                  state_ff <= S_DONE;
               end else begin
                  face_idx_ff <= face_idx_ff + FCW'(1);
                  state_ff    <= S_FACE;
               end
            end
            S_VB: state_ff <= S_VC;
            S_VC: state_ff <= S_VD;
            S_VD: begin
               step_ff  <= '0;
               state_ff <= S_MUL;
            end
            S_MUL: begin
               step_ff <= step_ff + 4'd1;
               if (step_ff == 4'd15) begin
                  state_ff <= S_DRAIN;
               end
            end
            S_DRAIN: state_ff <= S_CMP1;
            S_CMP1:  state_ff <= S_CMP2;
            S_CMP2: begin
               hits_ff <= hits_ff + COUNT_W'(hit);
               if (last_face) begin
                  state_ff <= S_DONE;
               end else begin
                  face_idx_ff <= face_idx_ff + FCW'(1);
                  state_ff    <= S_FACE;
               end
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff     <= 1'b1;
                  rsp_hit_count_ff <= hits_ff;
                  rsp_inside_ff    <= hits_ff[0];
                  state_ff         <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit_count  = rsp_hit_count_ff;
   assign rsp_inside_res = rsp_inside_ff;

   // capture query point, corners and vertices; form edges
   always_ff @(posedge clock) begin
      if (req_fire) begin
         px_ff <= req_x_coord;
         py_ff <= req_y_coord;
         pz_ff <= req_z_coord;
      end
      if (state_ff == S_VA) begin
         cb_ff <= face_rdata[2*INDEX_W-1:INDEX_W];
         cc_ff <= face_rdata[3*INDEX_W-1:2*INDEX_W];
      end
      if (state_ff == S_VB) begin
         {v0z_ff, v0y_ff, v0x_ff} <= vert_rdata;
      end
      if (state_ff == S_VC) begin
         {vbz_ff, vby_ff, vbx_ff} <= vert_rdata;
      end
      if (state_ff == S_VD) begin
         e1x_ff <= {vbx_ff[COORD_W-1], vbx_ff} - {v0x_ff[COORD_W-1], v0x_ff};
         e1y_ff <= {vby_ff[COORD_W-1], vby_ff} - {v0y_ff[COORD_W-1], v0y_ff};
         e1z_ff <= {vbz_ff[COORD_W-1], vbz_ff} - {v0z_ff[COORD_W-1], v0z_ff};
         e2x_ff <= {vert_rdata[COORD_W-1], vert_rdata[COORD_W-1:0]}
                   - {v0x_ff[COORD_W-1], v0x_ff};
         e2y_ff <= {vert_rdata[2*COORD_W-1], vert_rdata[2*COORD_W-1:COORD_W]}
                   - {v0y_ff[COORD_W-1], v0y_ff};
         e2z_ff <= {vert_rdata[3*COORD_W-1], vert_rdata[3*COORD_W-1:2*COORD_W]}
                   - {v0z_ff[COORD_W-1], v0z_ff};
         sx_ff  <= {px_ff[COORD_W-1], px_ff} - {v0x_ff[COORD_W-1], v0x_ff};
         sy_ff  <= {py_ff[COORD_W-1], py_ff} - {v0y_ff[COORD_W-1], v0y_ff};
         sz_ff  <= {pz_ff[COORD_W-1], pz_ff} - {v0z_ff[COORD_W-1], v0z_ff};
      end
   end

   // select multiplier operands for each step
   logic [DW-1:0]  op_a;
   logic [DW+1:0]  op_b;
   logic [AW2-1:0] wide_op;
   always_comb begin
      case (step_ff)
         4'd12, 4'd13: wide_op = qy_ff;
         4'd14, 4'd15: wide_op = vn_ff;
         default:      wide_op = qx_ff;
      endcase
   end

   always_comb begin
      case (step_ff)
         4'd0:  begin op_a = e1y_ff; op_b = {{2{e2x_ff[DW-1]}}, e2x_ff}; end
         4'd1:  begin op_a = e1x_ff; op_b = {{2{e2y_ff[DW-1]}}, e2y_ff}; end
         4'd2:  begin op_a = sy_ff;  op_b = {{2{e2x_ff[DW-1]}}, e2x_ff}; end
         4'd3:  begin op_a = sx_ff;  op_b = {{2{e2y_ff[DW-1]}}, e2y_ff}; end
         4'd4:  begin op_a = sx_ff;  op_b = {{2{e1y_ff[DW-1]}}, e1y_ff}; end
         4'd5:  begin op_a = sy_ff;  op_b = {{2{e1x_ff[DW-1]}}, e1x_ff}; end
         4'd6:  begin op_a = sy_ff;  op_b = {{2{e1z_ff[DW-1]}}, e1z_ff}; end
         4'd7:  begin op_a = sz_ff;  op_b = {{2{e1y_ff[DW-1]}}, e1y_ff}; end
         4'd8:  begin op_a = sz_ff;  op_b = {{2{e1x_ff[DW-1]}}, e1x_ff}; end
         4'd9:  begin op_a = sx_ff;  op_b = {{2{e1z_ff[DW-1]}}, e1z_ff}; end
         4'd10, 4'd12, 4'd14: begin
            op_a = (step_ff == 4'd10) ? e2x_ff : (step_ff == 4'd12) ? e2y_ff : e2z_ff;
            op_b = {1'b0, wide_op[LOW-1:0]};
         end
         default: begin
            op_a = (step_ff == 4'd11) ? e2x_ff : (step_ff == 4'd13) ? e2y_ff : e2z_ff;
            op_b = {wide_op[AW2-1], wide_op[AW2-1:LOW]};
         end
      endcase
   end

   logic [AW2-1:0] prod_in;
   assign prod_in = AW2'($signed(op_a) * $signed(op_b));

   // accumulate the previous product into its target
   logic [TW-1:0] acc_cur, acc_add, acc_in;
   logic          acc_sub;
   always_comb begin
      case (pstep_ff)
         4'd0, 4'd1: acc_cur = {{(TW-AW2){det_ff[AW2-1]}}, det_ff};
         4'd2, 4'd3: acc_cur = {{(TW-AW2){un_ff[AW2-1]}}, un_ff};
         4'd4, 4'd5: acc_cur = {{(TW-AW2){vn_ff[AW2-1]}}, vn_ff};
         4'd6, 4'd7: acc_cur = {{(TW-AW2){qx_ff[AW2-1]}}, qx_ff};
         4'd8, 4'd9: acc_cur = {{(TW-AW2){qy_ff[AW2-1]}}, qy_ff};
         default:    acc_cur = tn_ff;
      endcase
      acc_sub = (pstep_ff < 4'd10) && pstep_ff[0];
      if (pstep_ff >= 4'd10 && pstep_ff[0]) begin
         acc_add = {{(TW-AW2-LOW){prod_ff[AW2-1]}}, prod_ff, {LOW{1'b0}}};
      end else begin
         acc_add = {{(TW-AW2){prod_ff[AW2-1]}}, prod_ff};
      end
      acc_in = acc_sub ? acc_cur - acc_add : acc_cur + acc_add;
   end

   logic [RW-1:0] r_in;
   assign r_in = {{(RW-AW2){det_ff[AW2-1]}}, det_ff} - {{(RW-AW2){un_ff[AW2-1]}}, un_ff}
               - {{(RW-AW2){vn_ff[AW2-1]}}, vn_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         pvalid_ff <= 1'b0;
      end else begin
         pvalid_ff <= (state_ff == S_MUL);
      end
   end

   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      pstep_ff <= step_ff;
      if (state_ff == S_VD) begin
         det_ff <= '0;
         un_ff  <= '0;
         vn_ff  <= '0;
         qx_ff  <= '0;
         qy_ff  <= '0;
         tn_ff  <= '0;
      end else if (pvalid_ff) begin
         case (pstep_ff)
            4'd0, 4'd1: det_ff <= acc_in[AW2-1:0];
            4'd2, 4'd3: un_ff  <= acc_in[AW2-1:0];
            4'd4, 4'd5: vn_ff  <= acc_in[AW2-1:0];
            4'd6, 4'd7: qx_ff  <= acc_in[AW2-1:0];
            4'd8, 4'd9: qy_ff  <= acc_in[AW2-1:0];
            default:    tn_ff  <= acc_in;
         endcase
      end
      if (state_ff == S_CMP1) begin
         r_ff <= r_in;
      end
   end

`ifndef ASSERT_OFF
   a_acc_after_mul: assert property (@(posedge clock) disable iff (reset)
      pvalid_ff |-> $past(state_ff == S_MUL))
      else $error("accumulate without a multiply step");

   a_face_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FACE |-> face_idx_ff < n_ff)
      else $error("face index beyond clipped face count");

   a_parity: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_inside_res == rsp_hit_count[0])
      else $error("inside flag disagrees with hit count parity");

   a_hits_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CMP2 |-> 32'(hits_ff) <= 32'(face_idx_ff))
      else $error("hit count exceeds faces tested");
`endif

endmodule
`default_nettype wire

[verif/tb.sv]
// Testbench for point_in_mesh_ray_parity: randomized mesh loads and ray-parity queries.
`timescale 1ns / 1ps
module tb;
   import pim_pkg::*;

   localparam int ONE        = 65536;        // 1.0 in Q16.16
   localparam int IDLE_LIMIT = 200000;       // cycles with no handshake
   localparam int DEPTH      = 1024;
   localparam int MESH_USED  = 16;           // vertices and faces the queries walk

   typedef struct {
      command_type             cmd;
      logic [INDEX_W-1:0]      slot;
      logic signed [31:0]      x, y, z;
      logic [INDEX_W-1:0]      ca, cb, cc;
   } mesh_request_type;

   typedef struct {
      logic               parity;
      logic [COUNT_W-1:0] hits;
   } parity_report_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [1:0]         req_command = CMD_NONE;
   logic [INDEX_W-1:0] req_slot = '0;
   logic [COORD_W-1:0] req_x_coord = '0, req_y_coord = '0, req_z_coord = '0;
   logic [INDEX_W-1:0] req_corner_a = '0, req_corner_b = '0, req_corner_c = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic               rsp_inside_res;
   logic [COUNT_W-1:0] rsp_hit_count;
   logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [2:0]         paddr = '0;
   logic [31:0]        pwdata = '0;
   logic [31:0]        prdata;
   logic               pready;

   point_in_mesh_ray_parity u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_command(req_command),
      .req_slot(req_slot), .req_x_coord(req_x_coord), .req_y_coord(req_y_coord),
      .req_z_coord(req_z_coord), .req_corner_a(req_corner_a),
      .req_corner_b(req_corner_b), .req_corner_c(req_corner_c),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_inside_res(rsp_inside_res), .rsp_hit_count(rsp_hit_count),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // mirror of the mesh and the face count
   logic signed [31:0] mesh_vx [DEPTH];
   logic signed [31:0] mesh_vy [DEPTH];
   logic signed [31:0] mesh_vz [DEPTH];
   logic [INDEX_W-1:0] mesh_fa [DEPTH];
   logic [INDEX_W-1:0] mesh_fb [DEPTH];
   logic [INDEX_W-1:0] mesh_fc [DEPTH];
   logic [COUNT_W-1:0] faces_tested = '0;

   mesh_request_type  pending_requests [$];
   parity_report_type reports_due [$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_cycles = 0;
   int hold_stamp = 0;
   int mismatches = 0;
   int quiet_cycles = 0;

   // exact division-free crossing test of one face against a +Z ray
   function automatic logic ray_crosses_face(int f, logic signed [31:0] px,
                                              logic signed [31:0] py,
                                              logic signed [31:0] pz);
      logic signed [127:0] ox, oy, oz, e1x, e1y, e1z, e2x, e2y, e2z, sx, sy, sz;
      logic signed [127:0] det, un, vn, qx, qy, tn;
      ox = mesh_vx[mesh_fa[f]]; oy = mesh_vy[mesh_fa[f]]; oz = mesh_vz[mesh_fa[f]];
      e1x = mesh_vx[mesh_fb[f]]; e1y = mesh_vy[mesh_fb[f]]; e1z = mesh_vz[mesh_fb[f]];
      e2x = mesh_vx[mesh_fc[f]]; e2y = mesh_vy[mesh_fc[f]]; e2z = mesh_vz[mesh_fc[f]];
      sx = px; sy = py; sz = pz;
      e1x = e1x - ox; e1y = e1y - oy; e1z = e1z - oz;
      e2x = e2x - ox; e2y = e2y - oy; e2z = e2z - oz;
      sx = sx - ox; sy = sy - oy; sz = sz - oz;
      det = e1y * e2x - e1x * e2y;
      if (det == 0) return 1'b0;
      un = sy * e2x - sx * e2y;
      vn = sx * e1y - sy * e1x;
      qx = sy * e1z - sz * e1y;
      qy = sz * e1x - sx * e1z;
      tn = e2x * qx + e2y * qy + e2z * vn;
      if (det < 0) begin
         det = -det; un = -un; vn = -vn; tn = -tn;
      end
      return (un >= 0) && (vn >= 0) && (tn >= 0) && (un + vn <= det);
   endfunction

   // apply one accepted request to the mirror, queue a report for queries
   task automatic apply_request(mesh_request_type r);
      parity_report_type rep;
      int n;
      int hits;
      case (r.cmd)
         CMD_LOAD_VERTEX: begin
            mesh_vx[r.slot] = r.x; mesh_vy[r.slot] = r.y; mesh_vz[r.slot] = r.z;
         end
         CMD_LOAD_FACE: begin
            mesh_fa[r.slot] = r.ca; mesh_fb[r.slot] = r.cb; mesh_fc[r.slot] = r.cc;
         end
         CMD_QUERY: begin
            n = (faces_tested > DEPTH) ? DEPTH : faces_tested;
            hits = 0;
            for (int f = 0; f < n; f++)
               if (ray_crosses_face(f, r.x, r.y, r.z)) hits++;
            rep.parity = hits[0];
            rep.hits = hits[COUNT_W-1:0];
            reports_due = {reports_due, rep};
         end
         default: ;
      endcase
   endtask

   // drive requests from the pending queue
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid    <= 1'b1;
            req_command  <= pending_requests[0].cmd;
            req_slot     <= pending_requests[0].slot;
            req_x_coord  <= pending_requests[0].x;
            req_y_coord  <= pending_requests[0].y;
            req_z_coord  <= pending_requests[0].z;
            req_corner_a <= pending_requests[0].ca;
            req_corner_b <= pending_requests[0].cb;
            req_corner_c <= pending_requests[0].cc;
            void'(pending_requests.pop_front());
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // drive response ready, with random stalls and an occasional long hold
   int hold_left = 0;
   int hold_seen = 0;
   always @(posedge clock) begin
      if (hold_stamp != hold_seen) begin
         hold_seen <= hold_stamp;
         hold_left <= hold_cycles;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // track accepted requests and check responses
   always @(posedge clock) begin
      mesh_request_type r;
      parity_report_type exp_rep;
      if (!reset) begin
         if (req_valid && req_ready) begin
            r.cmd = command_type'(req_command);
            r.slot = req_slot;
            r.x = req_x_coord; r.y = req_y_coord; r.z = req_z_coord;
            r.ca = req_corner_a; r.cb = req_corner_b; r.cc = req_corner_c;
            apply_request(r);
         end
         if (rsp_valid && rsp_ready) begin
            if (reports_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("tb: response with none expected: inside=%0d hits=%0d",
                           rsp_inside_res, rsp_hit_count);
            end else begin
               exp_rep = reports_due.pop_front();
               if (rsp_inside_res !== exp_rep.parity || rsp_hit_count !== exp_rep.hits) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("tb: mismatch: expected inside=%0d hits=%0d, got inside=%0d hits=%0d",
                              exp_rep.parity, exp_rep.hits, rsp_inside_res, rsp_hit_count);
               end
            end
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (psel && penable))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("tb: FAIL");
         $finish;
      end
   end

   task automatic push_request(command_type cmd, int slot, int x, int y, int z,
                               int ca, int cb, int cc);
      mesh_request_type r;
      r.cmd = cmd; r.slot = INDEX_W'(slot); r.x = x; r.y = y; r.z = z;
      r.ca = INDEX_W'(ca); r.cb = INDEX_W'(cb); r.cc = INDEX_W'(cc);
      pending_requests = {pending_requests, r};
   endtask

   // coordinate near the origin on a quarter grid, sometimes with a random
   // fraction, rarely anywhere in range
   function automatic int pick_coord();
      int sel;
      sel = $urandom_range(99);
      if (sel < 8) return $urandom;
      if (sel < 30) return $urandom_range(0, 8 * ONE) - 4 * ONE;
      return ($urandom_range(0, 32) - 16) * (ONE / 4);
   endfunction

   // hold until every request is taken and every response is back
   task automatic drain();
      while (pending_requests.size() != 0 || req_valid || reports_due.size() != 0)
         @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic write_face_count(int value);
      @(posedge clock);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= {REG_FACE_COUNT, 2'b00}; pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      faces_tested = value[COUNT_W-1:0];
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
   endtask

   int fc_plan [8] = '{3, 16, 1, 8, 5, 0, 16, 12};
   int sel;

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      write_face_count(0);

      // fill the vertices and faces that queries walk, corners only among them
      send_idle_pct = 37; recv_idle_pct = 74;
      for (int i = 0; i < MESH_USED; i++)
         push_request(CMD_LOAD_VERTEX, i, pick_coord(), pick_coord(), pick_coord(), 0, 0, 0);
      for (int i = 0; i < MESH_USED; i++)
         push_request(CMD_LOAD_FACE, i, 0, 0, 0, $urandom_range(MESH_USED - 1),
                      $urandom_range(MESH_USED - 1), $urandom_range(MESH_USED - 1));
      push_request(CMD_QUERY, 0, 0, 0, 0, 0, 0, 0);
      drain();

      // directed: a right triangle both ways round, a degenerate face,
      // and one with coordinates at the extremes
      push_request(CMD_LOAD_VERTEX, 0, 0, 0, 0, 0, 0, 0);
      push_request(CMD_LOAD_VERTEX, 1, 4 * ONE, 0, 0, 0, 0, 0);
      push_request(CMD_LOAD_VERTEX, 2, 0, 4 * ONE, 0, 0, 0, 0);
      push_request(CMD_LOAD_VERTEX, 3, 8 * ONE, 0, 0, 0, 0, 0);
      push_request(CMD_LOAD_VERTEX, 1021, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0);
      push_request(CMD_LOAD_VERTEX, 1022, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 0, 0, 0);
      push_request(CMD_LOAD_VERTEX, 1023, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0);
      push_request(CMD_LOAD_FACE, 0, 0, 0, 0, 0, 1, 2);
      push_request(CMD_LOAD_FACE, 1, 0, 0, 0, 0, 2, 1);
      push_request(CMD_LOAD_FACE, 2, 0, 0, 0, 0, 1, 3);
      push_request(CMD_LOAD_FACE, 3, 0, 0, 0, 1021, 1022, 1023);
      drain();
      write_face_count(4);
      push_request(CMD_QUERY, 0, ONE, ONE, -5 * ONE, 0, 0, 0);     // below, crosses
      push_request(CMD_QUERY, 0, ONE, ONE, 0, 0, 0, 0);            // on the plane
      push_request(CMD_QUERY, 0, ONE, ONE, 5 * ONE, 0, 0, 0);      // above, misses
      push_request(CMD_QUERY, 0, 0, 0, -ONE, 0, 0, 0);             // on a corner
      push_request(CMD_QUERY, 0, 2 * ONE, 2 * ONE, -ONE, 0, 0, 0); // on the hypotenuse
      push_request(CMD_QUERY, 0, -ONE, ONE, -ONE, 0, 0, 0);        // outside
      push_request(CMD_QUERY, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0);
      push_request(CMD_QUERY, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0);
      push_request(CMD_QUERY, 0, 0, 0, 32'h8000_0000, 0, 0, 0);
      push_request(CMD_NONE, 1023, -1, -1, -1, 1023, 1023, 1023);
      drain();

      // random phases across several face counts
      for (int p = 0; p < 8; p++) begin
         send_idle_pct = (p < 3) ? 37 : (p < 6) ? 74 : 0;
         recv_idle_pct = (p < 3) ? 74 : (p < 6) ? 37 : 0;
         write_face_count(fc_plan[p]);
         for (int i = 0; i < 66; i++) begin
            sel = $urandom_range(99);
            if (sel < 20)
               push_request(CMD_LOAD_VERTEX, $urandom_range(1023), pick_coord(),
                            pick_coord(), pick_coord(), 0, 0, 0);
            else if (sel < 32)
               push_request(CMD_LOAD_FACE, $urandom_range(1023), 0, 0, 0,
                            $urandom_range(MESH_USED - 1), $urandom_range(MESH_USED - 1),
                            $urandom_range(MESH_USED - 1));
            else if (sel < 95)
               push_request(CMD_QUERY, $urandom_range(1023), pick_coord(),
                            pick_coord(), pick_coord(), 0, 0, 0);
            else
               push_request(CMD_NONE, $urandom_range(1023), $urandom, $urandom,
                            $urandom, $urandom_range(1023), $urandom_range(1023),
                            $urandom_range(1023));
         end
         // back up the response side long enough to stall the request side
         if (p == 1) begin
            hold_cycles = 2000;
            hold_stamp = hold_stamp + 1;
         end
         drain();
      end

      if (mismatches == 0 && reports_due.size() == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule
